// File: rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// Button click classifier package
// Shared phase codes, event codes, register indexes, reset values and types.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int CNT_W_DEF = 16;
  localparam int CFG_W     = 16;
  localparam int PHASE_W   = 3;
  localparam int EVENT_W   = 3;
  localparam int CLICKS_W  = 2;
  localparam int ADDR_W    = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DEB_PRESS = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PRESSED   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DEB_REL   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_WAIT      = 3'd4;

  localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
  localparam logic [EVENT_W-1:0] EV_SINGLE = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DOUBLE = 3'd2;
  localparam logic [EVENT_W-1:0] EV_LONG   = 3'd3;
  localparam logic [EVENT_W-1:0] EV_VLONG  = 3'd4;

  localparam logic [ADDR_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [ADDR_W-1:0] REG_INTERCLICK = 2'd1;
  localparam logic [ADDR_W-1:0] REG_LONG       = 2'd2;
  localparam logic [ADDR_W-1:0] REG_VLONG      = 2'd3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [CFG_W-1:0] INTERCLICK_RST = 16'd400;
  localparam logic [CFG_W-1:0] LONG_RST       = 16'd800;
  localparam logic [CFG_W-1:0] VLONG_RST      = 16'd2000;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] interclick_ticks;
    logic [CFG_W-1:0] long_ticks;
    logic [CFG_W-1:0] vlong_ticks;
  } cfg_t;

endpackage

// File: rtl/bcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Button click classifier configuration registers
// Holds the four timing thresholds written through the plain write port.
// ----------------------------------------------------------------------------
module bcc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bcc_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [bcc_pkg::CFG_W-1:0]  cfg_wdata,
  output bcc_pkg::cfg_t             cfg
);
  import bcc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_DEBOUNCE:   cfg_nxt.debounce_ticks   = cfg_wdata;
        REG_INTERCLICK: cfg_nxt.interclick_ticks = cfg_wdata;
        REG_LONG:       cfg_nxt.long_ticks       = cfg_wdata;
        REG_VLONG:      cfg_nxt.vlong_ticks      = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RST;
      cfg_r.interclick_ticks <= INTERCLICK_RST;
      cfg_r.long_ticks       <= LONG_RST;
      cfg_r.vlong_ticks      <= VLONG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/bcc_fsm.sv
// ----------------------------------------------------------------------------
// Button click classifier state machine
// Debounces the sampled level, counts hold and gap ticks and classifies
// the gesture; one event code per accepted tick.
// ----------------------------------------------------------------------------
module bcc_fsm #(
  parameter int COUNT_WIDTH = bcc_pkg::CNT_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        pressed,
  input  bcc_pkg::cfg_t               cfg,
  output logic [bcc_pkg::EVENT_W-1:0] event_code
);
  import bcc_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [CLICKS_W-1:0]    clicks_r, clicks_nxt;
  logic [EVENT_W-1:0]     ev;

  logic                   cnt_sat;
  logic [COUNT_WIDTH-1:0] cnt_up;
  logic [CMP_W-1:0]       cnt_up_x;
  logic [CMP_W-1:0]       deb_x, ic_x, long_x, vlong_x;

  assign cnt_sat  = (count_r == CNT_MAX);
  assign cnt_up   = cnt_sat ? count_r : count_r + COUNT_WIDTH'(1);
  assign cnt_up_x = CMP_W'(cnt_up);
  assign deb_x    = CMP_W'(cfg.debounce_ticks);
  assign ic_x     = CMP_W'(cfg.interclick_ticks);
  assign long_x   = CMP_W'(cfg.long_ticks);
  assign vlong_x  = CMP_W'(cfg.vlong_ticks);

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    clicks_nxt = clicks_r;
    ev         = EV_NONE;
    case (phase_r)
      PH_IDLE: begin
        if (pressed) begin
          phase_nxt = PH_DEB_PRESS;
          count_nxt = '0;
        end
      end
      PH_DEB_PRESS: begin
        count_nxt = cnt_up;
        if (cnt_up_x >= deb_x) begin
          if (pressed) begin
            phase_nxt = PH_PRESSED;
            count_nxt = '0;
          end else begin
            phase_nxt  = PH_IDLE;
            clicks_nxt = '0;
          end
        end
      end
      PH_PRESSED: begin
        count_nxt = cnt_up;
        if (!pressed) begin
          phase_nxt = PH_DEB_REL;
          count_nxt = '0;
        end else if (!cnt_sat) begin
          if (cnt_up_x == long_x) begin
            ev = EV_LONG;
          end else if (cnt_up_x == vlong_x) begin
            ev = EV_VLONG;
          end
        end
      end
      PH_DEB_REL: begin
        count_nxt = cnt_up;
        if (cnt_up_x >= deb_x) begin
          if (!pressed) begin
            if (clicks_r == '0) begin
              clicks_nxt = CLICKS_W'(1);
              phase_nxt  = PH_WAIT;
              count_nxt  = '0;
            end else begin
              clicks_nxt = '0;
              ev         = EV_DOUBLE;
              phase_nxt  = PH_IDLE;
            end
          end else begin
            phase_nxt = PH_PRESSED;
          end
        end
      end
      PH_WAIT: begin
        count_nxt = cnt_up;
        if (pressed) begin
          phase_nxt  = PH_DEB_PRESS;
          count_nxt  = '0;
          clicks_nxt = CLICKS_W'(2);
        end else if (cnt_up_x > ic_x) begin
          clicks_nxt = '0;
          ev         = EV_SINGLE;
          phase_nxt  = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      count_r  <= '0;
      clicks_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      clicks_r <= clicks_nxt;
    end
  end

  assign event_code = ev;

  a_single_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && ev == EV_SINGLE |=> phase_r == PH_IDLE && clicks_r == '0)
    else $error("single click did not return to idle");

  a_hold_event_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (ev == EV_LONG || ev == EV_VLONG) |-> phase_r == PH_PRESSED && pressed)
    else $error("hold event outside pressed phase");

  a_double_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && ev == EV_DOUBLE |=> phase_r == PH_IDLE && clicks_r == '0)
    else $error("double click did not return to idle");

endmodule

// File: rtl/bcc_out_buf.sv
// ----------------------------------------------------------------------------
// Button click classifier output buffer
// Result register with a skid stage so a new tick is taken while a result
// still waits on the output side.
// ----------------------------------------------------------------------------
module bcc_out_buf (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [bcc_pkg::EVENT_W-1:0] push_data,
  output logic                        can_push,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bcc_pkg::EVENT_W-1:0] out_data
);
  import bcc_pkg::*;

  logic               out_valid_r, out_valid_nxt;
  logic [EVENT_W-1:0] out_data_r, out_data_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  logic [EVENT_W-1:0] skid_data_r, skid_data_nxt;
  logic               pop;

  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds data while result register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ready |=> out_valid_r && !skid_valid_r)
    else $error("skid stage did not move into result register");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ready |=> out_data_r == $past(skid_data_r))
    else $error("skid data lost on transfer");

endmodule

// File: rtl/button_click_classifier_unit.sv
// ----------------------------------------------------------------------------
// Button click classifier
// Debounced button gesture detector: single, double, long and very long.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  in_     | slave     | tdata[0] button_pressed
//  out_    | master    | tdata[2:0] click_event
//  cfg_    | write     | addr selects debounce, interclick, long, vlong ticks
//
// Every tick transfer yields one result; the state machine and its counter
// update together, so one tick is taken per clock while the input is not stalled.
// The result register plus a skid stage keep input accepted while one result
// waits; input stalls only when both hold data.
// Reset is synchronous; it clears state and loads the default thresholds.
// ----------------------------------------------------------------------------
module button_click_classifier_unit #(
  parameter int COUNT_WIDTH = bcc_pkg::CNT_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bcc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [0] button_pressed
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bcc_pkg::OUT_TDATA_W-1:0] out_tdata,  // [2:0] click_event
  input  logic                            cfg_we,
  input  logic [bcc_pkg::ADDR_W-1:0]      cfg_addr,
  input  logic [bcc_pkg::CFG_W-1:0]       cfg_wdata
);
  import bcc_pkg::*;

  cfg_t               cfg;
  logic               step;
  logic               can_push;
  logic [EVENT_W-1:0] ev;
  logic [EVENT_W-1:0] ev_out;

  assign in_tready = can_push;
  assign step      = in_tvalid && can_push;

  bcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bcc_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .pressed    (in_tdata[0]),
    .cfg        (cfg),
    .event_code (ev)
  );

  bcc_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (ev),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (ev_out)
  );

  assign out_tdata = OUT_TDATA_W'(ev_out);

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier testbench
// Drives tick transfers with random and directed button levels, mirrors the
// debounce and gesture state machine in a scoreboard, and checks every event
// transfer in order. Thresholds are reloaded between phases, including the
// largest-gap corner, with random idling on both channels, a long output
// stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  import bcc_pkg::*;

  localparam longint unsigned COUNT_MAX = (64'd1 << CNT_W_DEF) - 1;
  localparam int CYCLE_LIMIT = 1000000;

  class click_scoreboard;
    logic [CFG_W-1:0] debounce_ticks, interclick_ticks, long_ticks, vlong_ticks;
    logic [PHASE_W-1:0] phase;
    longint unsigned tick_count;
    logic [CLICKS_W-1:0] clicks_seen;
    logic [EVENT_W-1:0] pending_events[$];
    int errors;
    int ticks_noted;
    int event_tally[5];

    function void reset_state();
      debounce_ticks = DEBOUNCE_RST;
      interclick_ticks = INTERCLICK_RST;
      long_ticks = LONG_RST;
      vlong_ticks = VLONG_RST;
      phase = PH_IDLE;
      tick_count = 0;
      clicks_seen = '0;
      pending_events.delete();
    endfunction

    function void set_reg(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
      case (addr)
        REG_DEBOUNCE: debounce_ticks = value;
        REG_INTERCLICK: interclick_ticks = value;
        REG_LONG: long_ticks = value;
        REG_VLONG: vlong_ticks = value;
        default: ;
      endcase
    endfunction

    function bit count_up();
      if (tick_count >= COUNT_MAX) begin
        tick_count = COUNT_MAX;
        return 1'b0;
      end
      tick_count++;
      return 1'b1;
    endfunction

    function void note_tick(bit pressed);
      logic [EVENT_W-1:0] ev;
      bit moved;
      ev = EV_NONE;
      case (phase)
        PH_IDLE: begin
          if (pressed) begin
            phase = PH_DEB_PRESS;
            tick_count = 0;
          end
        end
        PH_DEB_PRESS: begin
          void'(count_up());
          if (tick_count >= debounce_ticks) begin
            if (pressed) begin
              phase = PH_PRESSED;
              tick_count = 0;
            end else begin
              phase = PH_IDLE;
              clicks_seen = '0;
            end
          end
        end
        PH_PRESSED: begin
          moved = count_up();
          if (!pressed) begin
            phase = PH_DEB_REL;
            tick_count = 0;
          end else if (moved) begin
            if (tick_count == long_ticks) ev = EV_LONG;
            else if (tick_count == vlong_ticks) ev = EV_VLONG;
          end
        end
        PH_DEB_REL: begin
          void'(count_up());
          if (tick_count >= debounce_ticks) begin
            if (!pressed) begin
              if (clicks_seen == 0) begin
                clicks_seen = 2'd1;
                phase = PH_WAIT;
                tick_count = 0;
              end else begin
                clicks_seen = '0;
                ev = EV_DOUBLE;
                phase = PH_IDLE;
              end
            end else begin
              phase = PH_PRESSED;
            end
          end
        end
        PH_WAIT: begin
          void'(count_up());
          if (pressed) begin
            phase = PH_DEB_PRESS;
            tick_count = 0;
            clicks_seen = 2'd2;
          end else if (tick_count > interclick_ticks) begin
            clicks_seen = '0;
            ev = EV_SINGLE;
            phase = PH_IDLE;
          end
        end
        default: phase = PH_IDLE;
      endcase
      pending_events.push_back(ev);
      ticks_noted++;
    endfunction

    function void check_result(logic [EVENT_W-1:0] got);
      logic [EVENT_W-1:0] want;
      if (got <= EV_VLONG) event_tally[got]++;
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: click_event expected none, actual %0d", $time, got);
        return;
      end
      want = pending_events.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: click_event expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = REG_DEBOUNCE;
  logic [CFG_W-1:0] cfg_wdata = '0;

  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int settings_used = 0;
  click_scoreboard sb = new();

  button_click_classifier_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata[EVENT_W-1:0]);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  task automatic send_tick(input bit level);
    while (!no_idle && $urandom_range(0, 99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - 1){1'b0}}, level};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(level);
  endtask

  task automatic send_run(input bit level, input int n);
    repeat (n) send_tick(level);
  endtask

  task automatic wait_delivered();
    in_tvalid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_thresholds(input int deb, gap, lng, vlng);
    logic [ADDR_W-1:0] addrs[4];
    int vals[4];
    addrs = '{REG_DEBOUNCE, REG_INTERCLICK, REG_LONG, REG_VLONG};
    vals = '{deb, gap, lng, vlng};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= addrs[i];
      cfg_wdata <= vals[i][CFG_W-1:0];
      @(posedge clk);
      sb.set_reg(addrs[i], vals[i][CFG_W-1:0]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_setting(input int deb, gap, lng, vlng, input int n_items,
                             input bit squeeze);
    int start;
    int hold;
    int part;
    bit stalled;
    bit paused;
    wait_delivered();
    load_thresholds(deb, gap, lng, vlng);
    start = sb.ticks_noted;
    stalled = 1'b0;
    paused = 1'b0;
    while (sb.ticks_noted - start < n_items) begin
      if (squeeze && !stalled && sb.ticks_noted - start > n_items / 3) begin
        hold_req = 1'b1;
        stalled = 1'b1;
      end
      if (squeeze && !paused && sb.ticks_noted - start > 2 * n_items / 3) begin
        wait_delivered();
        paused = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
        1: begin
          send_run(1'b1, $urandom_range(1, deb));
          send_run(1'b0, $urandom_range(1, deb + 2));
        end
        default: begin
          hold = $urandom_range(deb + 1, deb + vlng + 3);
          if ($urandom_range(0, 3) == 0) begin
            part = $urandom_range(1, hold);
            send_run(1'b1, part);
            send_run(1'b0, $urandom_range(1, deb));
            hold = hold - part + 1;
          end
          send_run(1'b1, hold);
          send_run(1'b0, $urandom_range(deb, deb + gap + 3));
        end
      endcase
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    int deb, gap, lng, vlng;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    sb.reset_state();
    @(posedge clk);

    // Reset thresholds first, then short directed gestures.
    send_run(1'b1, 30);
    send_run(1'b0, 30);
    wait_delivered();
    load_thresholds(2, 3, 4, 6);
    send_run(1'b1, 8);
    send_run(1'b0, 7);
    send_run(1'b1, 1);
    send_run(1'b0, 2);
    send_run(1'b1, 4);
    send_run(1'b0, 1);
    send_run(1'b1, 2);
    send_run(1'b0, 3);
    send_run(1'b1, 3);
    send_run(1'b0, 4);
    wait_delivered();
    load_thresholds(1, 2, 3, 3);
    send_run(1'b1, 6);
    send_run(1'b0, 5);

    // A gap that never elapses keeps the first click pending until the next press.
    no_idle = 1'b1;
    wait_delivered();
    load_thresholds(1, 65535, 65535, 65535);
    send_run(1'b1, 10);
    send_run(1'b0, 40);
    send_run(1'b1, 3);
    send_run(1'b0, 3);
    no_idle = 1'b0;

    for (int s = 0; s < 8; s++) begin
      deb = $urandom_range(1, 4);
      gap = $urandom_range(1, 12);
      lng = $urandom_range(1, 20);
      vlng = $urandom_range(1, 40);
      if (s == 0) begin
        deb = 1;
        gap = 1;
        lng = 1;
        vlng = 1;
      end
      if (s == 1) vlng = lng;
      no_idle = (s == 2);
      run_setting(deb, gap, lng, vlng, 200, s == 3);
    end
    no_idle = 1'b0;

    wait_delivered();
    repeat (10) @(posedge clk);
    if (sb.pending_events.size() != 0) sb.errors++;
    $display("tb_top: %0d tick transfers over %0d threshold settings, largest gap included",
             sb.ticks_noted, settings_used);
    $display("tb_top: events seen: %0d single, %0d double, %0d long, %0d very long",
             sb.event_tally[EV_SINGLE], sb.event_tally[EV_DOUBLE],
             sb.event_tally[EV_LONG], sb.event_tally[EV_VLONG]);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
